/* hw/rtl/r2fft_pkg.sv */
// Shared types and constants for the radix-2 FFT block.
package r2fft_pkg;

  localparam int unsigned StoreBits = 40;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned TwBits = 18;
  localparam int unsigned TwFrac = TwBits - 2;
  localparam int unsigned MaxLg = 12;
  localparam int unsigned MinLg = 8;

  typedef logic signed [StoreBits-1:0] word_t;
  typedef logic signed [TwBits-1:0] tw_t;

  typedef enum logic [0:0] {
    CFG_LOG2_POINTS = 1'b0,
    CFG_INVERSE     = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

endpackage

/* hw/rtl/r2fft_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module r2fft_ram #(
  parameter int unsigned Width = 80,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/r2fft_twid.sv */
// Twiddle ROM per transform size, registered read: cos and sin for index t < N/2.
module r2fft_twid (
  input  logic                    clk_i,
  input  logic [3:0]              lg_i,
  input  logic [10:0]             t_i,
  output r2fft_pkg::tw_t          cos_o,
  output r2fft_pkg::tw_t          sin_o
);
  import r2fft_pkg::*;

  localparam logic [63:0] Q30One    = 64'd1 << 30;
  localparam logic [63:0] RoundHalf = 64'd1 << (29 - TwFrac);

  // Per-size ROM of the first quadrant; quadrant folding done here.
  tw_t rom [5][1025];

  logic [11:0] n_half;
  logic [11:0] q;
  logic [11:0] t_ext;
  logic [11:0] rc;
  logic [11:0] rs;
  logic        neg_c;
  logic [2:0]  sel;

  always_comb begin
    sel    = 3'(lg_i - 4'(MinLg));
    q      = 12'(1) << (lg_i - 4'd2);
    n_half = 12'(1) << (lg_i - 4'd1);
    t_ext  = {1'b0, t_i};
    if (t_ext <= q) begin
      rc = q - t_ext; rs = t_ext; neg_c = 1'b0;
    end else begin
      rc = t_ext - q; rs = n_half - t_ext; neg_c = 1'b1;
    end
  end

  // sin(2*pi*r/2^lg) by a Q30 Taylor series, rounded to Q1.16; all elaboration-time.
  for (genvar g = 0; g < 5; g++) begin : g_size
    for (genvar r = 0; r <= 1024; r++) begin : g_ent
      localparam int unsigned Lg = g + MinLg;
      localparam logic [63:0] X  = (64'(r) * 64'hC90FDAA221) >> (Lg + 7);
      localparam logic [63:0] X2 = (X * X) >> 30;
      localparam logic [63:0] T0 = Q30One - ((X2 * Q30One) >> 30) / 64'd156;
      localparam logic [63:0] T1 = Q30One - ((X2 * T0) >> 30) / 64'd110;
      localparam logic [63:0] T2 = Q30One - ((X2 * T1) >> 30) / 64'd72;
      localparam logic [63:0] T3 = Q30One - ((X2 * T2) >> 30) / 64'd42;
      localparam logic [63:0] T4 = Q30One - ((X2 * T3) >> 30) / 64'd20;
      localparam logic [63:0] T5 = Q30One - ((X2 * T4) >> 30) / 64'd6;
      localparam logic [63:0] S  = (X * T5) >> 30;
      localparam tw_t Val = tw_t'((S + RoundHalf) >> (30 - TwFrac));
      assign rom[g][r] = (r <= (1 << (Lg - 2))) ? Val : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_o <= neg_c ? -rom[sel][rc[10:0]] : rom[sel][rc[10:0]];
    sin_o <= rom[sel][rs[10:0]];
  end
endmodule

/* hw/rtl/r2fft_bfly.sv */
// Shared butterfly unit: complex multiply, round, add/sub; two-stage pipeline.
module r2fft_bfly (
  input  logic                 clk_i,
  input  r2fft_pkg::word_t     ar_i,
  input  r2fft_pkg::word_t     ai_i,
  input  r2fft_pkg::word_t     br_i,
  input  r2fft_pkg::word_t     bi_i,
  input  r2fft_pkg::tw_t       wr_i,
  input  r2fft_pkg::tw_t       wi_i,
  output r2fft_pkg::word_t     xr_o,
  output r2fft_pkg::word_t     xi_o,
  output r2fft_pkg::word_t     yr_o,
  output r2fft_pkg::word_t     yi_o
);
  import r2fft_pkg::*;

  logic signed [57:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  word_t ar_q, ai_q;
  logic signed [58:0] sr, si;
  word_t vr, vi;

  always_ff @(posedge clk_i) begin
    p_rr_q <= br_i * wr_i;
    p_ii_q <= bi_i * wi_i;
    p_ri_q <= br_i * wi_i;
    p_ir_q <= bi_i * wr_i;
    ar_q <= ar_i;
    ai_q <= ai_i;
  end

  always_comb begin
    sr = 59'(p_rr_q) - 59'(p_ii_q) + 59'(1 << (TwFrac - 1));
    si = 59'(p_ri_q) + 59'(p_ir_q) + 59'(1 << (TwFrac - 1));
    vr = word_t'(sr >>> TwFrac);
    vi = word_t'(si >>> TwFrac);
  end

  always_ff @(posedge clk_i) begin
    xr_o <= ar_q + vr;
    xi_o <= ai_q + vi;
    yr_o <= ar_q - vr;
    yi_o <= ai_q - vi;
  end
endmodule

/* hw/rtl/radix2_complex_fft_top.sv */
// Top level: load/fetch streaming, sequencer for bit reverse, butterflies and scaling.
// Loads are taken in S_IDLE with no output pending; the frame's last one starts a
//   transform: bit-reverse reorder, (N/2)*log2N butterflies, then scaling (inverse
//   only), input held off. One shared butterfly, each done before the next starts
//   (one RAM read a cycle, 2-stage math). Fetch: read data goes via S_FREAD to the
//   output register, an empty result straight to it; input waits until it is taken.
// Reset (rst_ni low, async) clears counters, flags and config to log2_points=10;
//   the sample store has no reset, only written entries are ever read.
module radix2_complex_fft_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // real_in[23:0], imag_in[47:24]
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // real_out[39:0], imag_out[79:40]
  output logic        m_axis_tlast,   // last_bin
  output logic        m_axis_tuser    // empty_res
);
  import r2fft_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FREAD, S_FWAIT, S_REV_RA, S_REV_RB, S_REV_WA, S_REV_WB,
    S_BF_RA, S_BF_RB, S_BF_W1, S_BF_W2, S_BF_W3, S_BF_WA, S_BF_WB,
    S_SC_R, S_SC_W1, S_SC_W
  } st_e;

  st_e st_q;
  logic [3:0] lg_cfg_q;
  logic inv_q;
  logic [12:0] load_cnt_q, fetch_cnt_q;
  logic ready_q;
  logic [11:0] i_q, j_q;
  logic [3:0] stg_q;         // butterfly stage: half = 1<<stg
  logic [10:0] bf_q;         // butterfly index in stage
  word_t ar_q, ai_q, br_q, bi_q;
  logic ov_q;
  logic [79:0] od_q;
  logic ol_q, oe_q;
  logic fetch_last_q;

  logic [3:0] lg;
  logic [12:0] n;
  always_comb begin
    lg = lg_cfg_q;
    if (lg < 4'(MinLg)) lg = 4'(MinLg);
    if (lg > 4'(MaxLg)) lg = 4'(MaxLg);
    n = 13'(1) << lg;
  end

  // bit reversal of i_q within lg bits
  logic [11:0] rev;
  always_comb begin
    rev = '0;
    for (int b = 0; b < 12; b++) begin
      if (b < int'(lg)) rev[int'(lg) - 1 - b] = i_q[b];
    end
  end

  // butterfly addressing
  logic [11:0] half, a_addr, b_addr, kmask;
  logic [10:0] tw_idx;
  always_comb begin
    half = 12'(1) << stg_q;
    kmask = half - 12'd1;
    a_addr = ((12'(bf_q) & ~kmask) << 1) | (12'(bf_q) & kmask);
    b_addr = a_addr | half;
    tw_idx = 11'((12'(bf_q) & kmask) << (lg - 4'd1 - stg_q));
  end

  logic we;
  logic [11:0] waddr, raddr;
  logic [79:0] wdata, rdata;

  r2fft_ram #(.Width(80), .Depth(4096)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  tw_t wc, ws;
  r2fft_twid u_twid (.clk_i, .lg_i(lg), .t_i(tw_idx), .cos_o(wc), .sin_o(ws));

  word_t xr, xi, yr, yi;
  tw_t wi_sel;
  assign wi_sel = inv_q ? ws : -ws;
  r2fft_bfly u_bfly (
    .clk_i, .ar_i(ar_q), .ai_i(ai_q), .br_i(br_q), .bi_i(bi_q),
    .wr_i(wc), .wi_i(wi_sel), .xr_o(xr), .xi_o(xi), .yr_o(yr), .yi_o(yi)
  );

  logic acc_in;
  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  word_t rd_r, rd_i;
  assign rd_r = rdata[39:0];
  assign rd_i = rdata[79:40];

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    case (st_q)
      S_IDLE: begin
        raddr = fetch_cnt_q[11:0];
        if (acc_in && s_axis_tuser == MODE_LOAD) begin
          we = 1'b1; waddr = load_cnt_q[11:0];
          wdata = {word_t'(signed'(s_axis_tdata[47:24])),
                   word_t'(signed'(s_axis_tdata[23:0]))};
        end
      end
      S_REV_RA: raddr = i_q;
      S_REV_RB: raddr = j_q;
      // swap once per pair, from its lower index only
      S_REV_WA: begin we = (i_q < j_q); waddr = i_q; wdata = {bi_q, br_q}; end
      S_REV_WB: begin we = (i_q < j_q); waddr = j_q; wdata = {ai_q, ar_q}; end
      S_BF_RA: raddr = a_addr;
      S_BF_RB: raddr = b_addr;
      S_BF_WA: begin we = 1'b1; waddr = a_addr; wdata = {xi, xr}; end
      S_BF_WB: begin we = 1'b1; waddr = b_addr; wdata = {yi, yr}; end
      S_SC_R: raddr = i_q;
      S_SC_W: begin
        we = 1'b1; waddr = i_q;
        wdata = {word_t'(ai_q >>> lg), word_t'(ar_q >>> lg)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; lg_cfg_q <= 4'd10; inv_q <= 1'b0;
      load_cnt_q <= '0; fetch_cnt_q <= '0; ready_q <= 1'b0;
      i_q <= '0; j_q <= '0; stg_q <= '0; bf_q <= '0;
      ar_q <= '0; ai_q <= '0; br_q <= '0; bi_q <= '0;
      ov_q <= 1'b0; od_q <= '0; ol_q <= 1'b0; oe_q <= 1'b0; fetch_last_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LOG2_POINTS) lg_cfg_q <= cfg_data_i;
        else inv_q <= cfg_data_i[0];
        load_cnt_q <= '0; fetch_cnt_q <= '0; ready_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: if (acc_in) begin
          if (s_axis_tuser == MODE_LOAD) begin
            ready_q <= 1'b0; fetch_cnt_q <= '0;
            if (load_cnt_q + 13'd1 >= n) begin
              load_cnt_q <= '0; i_q <= '0; st_q <= S_REV_RA;
            end else begin
              load_cnt_q <= load_cnt_q + 13'd1;
            end
          end else if (!ready_q) begin
            ov_q <= 1'b1; od_q <= '0; ol_q <= 1'b0; oe_q <= 1'b1;
          end else begin
            fetch_last_q <= (fetch_cnt_q + 13'd1 >= n);
            if (fetch_cnt_q + 13'd1 >= n) begin
              fetch_cnt_q <= '0; ready_q <= 1'b0;
            end else begin
              fetch_cnt_q <= fetch_cnt_q + 13'd1;
            end
            st_q <= S_FREAD;
          end
        end
        S_FREAD: begin
          ov_q <= 1'b1; od_q <= rdata; ol_q <= fetch_last_q; oe_q <= 1'b0;
          st_q <= S_IDLE;
        end
        S_REV_RA: begin j_q <= rev; st_q <= S_REV_RB; end
        S_REV_RB: begin ar_q <= rd_r; ai_q <= rd_i; st_q <= S_FWAIT; end
        S_FWAIT: begin br_q <= rd_r; bi_q <= rd_i; st_q <= S_REV_WA; end
        S_REV_WA: st_q <= S_REV_WB;
        S_REV_WB: begin
          if (13'(i_q) + 13'd1 >= n) begin
            stg_q <= '0; bf_q <= '0; st_q <= S_BF_RA;
          end else begin
            i_q <= i_q + 12'd1; st_q <= S_REV_RA;
          end
        end
        S_BF_RA: st_q <= S_BF_RB;
        S_BF_RB: begin ar_q <= rd_r; ai_q <= rd_i; st_q <= S_BF_W1; end
        S_BF_W1: begin br_q <= rd_r; bi_q <= rd_i; st_q <= S_BF_W2; end
        // wait states W2 and W3 while the butterfly pipeline produces x and y
        S_BF_W2: st_q <= S_BF_W3;
        S_BF_W3: st_q <= S_BF_WA;
        S_BF_WA: st_q <= S_BF_WB;
        S_BF_WB: begin
          if (13'(bf_q) + 13'd1 >= (n >> 1)) begin
            bf_q <= '0;
            if (stg_q + 4'd1 >= lg) begin
              i_q <= '0;
              if (inv_q) st_q <= S_SC_R;
              else begin ready_q <= 1'b1; st_q <= S_IDLE; end
            end else begin
              stg_q <= stg_q + 4'd1; st_q <= S_BF_RA;
            end
          end else begin
            bf_q <= bf_q + 11'd1; st_q <= S_BF_RA;
          end
        end
        S_SC_R: st_q <= S_SC_W1;
        S_SC_W1: begin ar_q <= rd_r; ai_q <= rd_i; st_q <= S_SC_W; end
        S_SC_W: begin
          if (13'(i_q) + 13'd1 >= n) begin
            ready_q <= 1'b1; st_q <= S_IDLE;
          end else begin
            i_q <= i_q + 12'd1; st_q <= S_SC_R;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tlast = ol_q;
  assign m_axis_tuser = oe_q;

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("empty result carries data");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !s_axis_tready)
    else $error("accepted while transforming");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> (st_q == S_IDLE && load_cnt_q == '0))
    else $error("results ready outside idle");
endmodule
